[hdl/assert_macros.svh]
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers, clocked on i_clk, disabled during reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every edge out of reset.
`define ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error("%m: assertion failed");

// When ante holds, cons must hold in the next cycle.
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("%m: assertion failed");

`endif

[hdl/weod_pkg.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// weod_pkg
// Shared constants and types for the window energy onset detector.
// ---------------------------------------------------------------------------
package weod_pkg;

    localparam int CHANNELS    = 2;
    localparam int SAMPLE_BITS = 16;

    // Only two sample fields exist on the port.
    localparam int LANES = (CHANNELS < 2) ? CHANNELS : 2;

    localparam int FIELD_W = 16;
    localparam int SQ_W    = 2 * SAMPLE_BITS;
    localparam int E_W     = 48;
    localparam int SUM_W   = E_W + 2;
    localparam int LEN_W   = 16;
    localparam int IDX_W   = 32;
    localparam int CH_W    = 2;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 48;

    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LENGTH   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RISE_THRESHOLD  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_CHANNELS = 2'd2;

    localparam logic [LEN_W-1:0] RST_WINDOW_LENGTH   = 16'd4410;
    localparam logic [E_W-1:0]   RST_RISE_THRESHOLD  = 48'd1073741824;
    localparam logic [CH_W-1:0]  RST_ACTIVE_CHANNELS = 2'd2;

    localparam logic [E_W-1:0] E_MAX = {E_W{1'b1}};

    typedef logic [LANES-1:0][SQ_W-1:0]        t_sq_vec;
    typedef logic signed [SAMPLE_BITS-1:0]     t_sample;
    typedef logic [LANES-1:0][SAMPLE_BITS-1:0] t_sample_vec;

    // A finished window handed from the accumulator to the evaluator.
    typedef struct packed {
        logic [E_W-1:0]   energy;
        logic [E_W-1:0]   prev;
        logic             have_prev;
        logic [IDX_W-1:0] start;
    } t_closed;

endpackage
`default_nettype wire

[hdl/weod_square_lane.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// weod_square_lane
// One channel lane: registered square of a signed sample.
// ---------------------------------------------------------------------------
module weod_square_lane (
    input  wire logic                       i_clk,
    input  wire logic                       i_en,
    input  wire weod_pkg::t_sample          i_sample,
    output logic [weod_pkg::SQ_W-1:0]       o_square
);

    logic signed [weod_pkg::SQ_W-1:0] prod;
    logic [weod_pkg::SQ_W-1:0]        r_square;

    assign prod = i_sample * i_sample;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_square <= $unsigned(prod);
        end
    end

    assign o_square = r_square;

endmodule
`default_nettype wire

[hdl/weod_window_acc.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// weod_window_acc
// Merge stage: sums active lanes into the saturating window accumulator and
// detects window close.
// ---------------------------------------------------------------------------
module weod_window_acc (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_step,
    input  wire weod_pkg::t_sq_vec             i_square,
    input  wire logic [weod_pkg::LEN_W-1:0]    i_window_length,
    input  wire logic [weod_pkg::CH_W-1:0]     i_active_channels,
    output logic                               o_close,
    output weod_pkg::t_closed                  o_closed
);

    logic [weod_pkg::E_W-1:0]   r_acc, n_acc;
    logic [weod_pkg::E_W-1:0]   r_prev;
    logic                       r_have;
    logic [weod_pkg::LEN_W-1:0] r_pos;
    logic [weod_pkg::IDX_W-1:0] r_start;

    logic [weod_pkg::CH_W-1:0]  chans;
    logic [weod_pkg::SUM_W-1:0] sum;
    logic [weod_pkg::LEN_W-1:0] len;
    logic [weod_pkg::LEN_W-1:0] pos_next;
    logic                       closes;
    logic [weod_pkg::LEN_W:0]   closed_len;

    always_comb begin
        priority if (i_active_channels == '0) begin
            chans = weod_pkg::CH_W'(1);
        end else if (i_active_channels > weod_pkg::CH_W'(weod_pkg::LANES)) begin
            chans = weod_pkg::CH_W'(weod_pkg::LANES);
        end else begin
            chans = i_active_channels;
        end
    end

    // Sum of non-negative terms: one final clamp equals a clamp per add.
    always_comb begin
        sum = weod_pkg::SUM_W'(r_acc);
        for (int c = 0; c < weod_pkg::LANES; c++) begin
            if (weod_pkg::CH_W'(c) < chans) begin
                sum = sum + weod_pkg::SUM_W'(i_square[c]);
            end
        end
        n_acc = (sum > weod_pkg::SUM_W'(weod_pkg::E_MAX)) ? weod_pkg::E_MAX
                                                          : sum[weod_pkg::E_W-1:0];
    end

    assign len        = (i_window_length == '0) ? weod_pkg::LEN_W'(1) : i_window_length;
    assign pos_next   = r_pos + weod_pkg::LEN_W'(1);
    assign closes     = (pos_next == '0) || (pos_next >= len);
    assign closed_len = {(pos_next == '0), pos_next};

    assign o_close            = i_step && closes;
    assign o_closed.energy    = n_acc;
    assign o_closed.prev      = r_prev;
    assign o_closed.have_prev = r_have;
    assign o_closed.start     = r_start;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc   <= '0;
            r_prev  <= '0;
            r_have  <= 1'b0;
            r_pos   <= '0;
            r_start <= '0;
        end else if (i_step) begin
            if (closes) begin
                r_prev  <= n_acc;
                r_have  <= 1'b1;
                r_acc   <= '0;
                r_pos   <= '0;
                r_start <= r_start + weod_pkg::IDX_W'(closed_len);
            end else begin
                r_acc <= n_acc;
                r_pos <= pos_next;
            end
        end
    end

endmodule
`default_nettype wire

[hdl/weod_onset_out.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// weod_onset_out
// Evaluates a closed window against the previous one and holds the result
// in the output register.
// ---------------------------------------------------------------------------
module weod_onset_out (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_close,
    input  wire weod_pkg::t_closed           i_closed,
    input  wire logic [weod_pkg::E_W-1:0]    i_threshold,
    input  wire logic                        i_out_ready,
    output logic                             o_advance,
    output logic                             o_out_valid,
    output logic [weod_pkg::IDX_W-1:0]       o_onset_sample,
    output logic [weod_pkg::E_W-1:0]         o_window_energy,
    output logic [weod_pkg::E_W-1:0]         o_energy_rise
);

    logic                       r_ev_valid;
    weod_pkg::t_closed          r_ev;
    logic                       r_out_valid;
    logic [weod_pkg::IDX_W-1:0] r_onset;
    logic [weod_pkg::E_W-1:0]   r_energy;
    logic [weod_pkg::E_W-1:0]   r_rise;

    logic [weod_pkg::E_W:0]     diff;
    logic                       hit;
    logic                       out_free;

    // Borrow bit set means energy fell below the reference.
    assign diff     = {1'b0, r_ev.energy} - {1'b0, r_ev.prev};
    assign hit      = r_ev_valid && r_ev.have_prev && !diff[weod_pkg::E_W]
                      && (diff[weod_pkg::E_W-1:0] > i_threshold);
    assign out_free = !r_out_valid || i_out_ready;
    assign o_advance = !r_ev_valid || !hit || out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ev_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_advance) begin
                r_ev_valid <= i_close;
            end
            if (o_advance && hit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_advance) begin
            r_ev <= i_closed;
        end
        if (o_advance && hit) begin
            r_onset  <= r_ev.start;
            r_energy <= r_ev.energy;
            r_rise   <= diff[weod_pkg::E_W-1:0];
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_onset_sample  = r_onset;
    assign o_window_energy = r_energy;
    assign o_energy_rise   = r_rise;

endmodule
`default_nettype wire

[hdl/window_energy_onset_detector.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// window_energy_onset_detector
// Non-overlapping window energy with onset flag on a rise above threshold.
// ---------------------------------------------------------------------------
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+----------------------------
//  in      | sink      | i_in_valid / o_in_ready | i_sample_ch0, i_sample_ch1
//  out     | source    | o_out_valid/i_out_ready | o_onset_sample,
//          |           |                         | o_window_energy, o_energy_rise
//  cfg     | sink      | i_cfg_we (no wait)      | i_cfg_index, i_cfg_data
//
//  One frame per cycle sustained unless an onset waits on a stalled output.
//  The squares register at the input transfer, the window register adds them
//  and hands a closing window to the evaluator register, and the output
//  register then loads the onset.
//  Reset (synchronous, active low) clears all control state and loads the
//  register defaults; no clearing pass.
//  A stalled output holds one result; frames keep flowing until a second
//  onset reaches the evaluator, which then backs up the pipe to the input.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module window_energy_onset_detector (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    // config
    input  wire logic                               i_cfg_we,
    input  wire logic [weod_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [weod_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    // frame in
    input  wire logic                               i_in_valid,
    output logic                                    o_in_ready,
    input  wire logic signed [weod_pkg::FIELD_W-1:0] i_sample_ch0,
    input  wire logic signed [weod_pkg::FIELD_W-1:0] i_sample_ch1,
    // onset out
    output logic                                    o_out_valid,
    input  wire logic                               i_out_ready,
    output logic [weod_pkg::IDX_W-1:0]              o_onset_sample,
    output logic [weod_pkg::E_W-1:0]                o_window_energy,
    output logic [weod_pkg::E_W-1:0]                o_energy_rise
);

    // Config registers
    logic [weod_pkg::LEN_W-1:0] r_window_length;
    logic [weod_pkg::E_W-1:0]   r_rise_threshold;
    logic [weod_pkg::CH_W-1:0]  r_active_channels;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_length   <= weod_pkg::RST_WINDOW_LENGTH;
            r_rise_threshold  <= weod_pkg::RST_RISE_THRESHOLD;
            r_active_channels <= weod_pkg::RST_ACTIVE_CHANNELS;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                weod_pkg::CFG_WINDOW_LENGTH: begin
                    r_window_length <= i_cfg_data[weod_pkg::LEN_W-1:0];
                end
                weod_pkg::CFG_RISE_THRESHOLD: begin
                    r_rise_threshold <= i_cfg_data[weod_pkg::E_W-1:0];
                end
                weod_pkg::CFG_ACTIVE_CHANNELS: begin
                    r_active_channels <= i_cfg_data[weod_pkg::CH_W-1:0];
                end
                default: begin
                    // unmapped index: dropped
                end
            endcase
        end
    end

    // Pipeline control: square stage valid, advances with the evaluator.
    logic                  r_s1_valid;
    logic                  advance;
    logic                  in_xfer;
    logic                  step;
    logic                  close;
    weod_pkg::t_closed     closed;
    weod_pkg::t_sq_vec     square;
    weod_pkg::t_sample_vec samples;

    assign o_in_ready = !r_s1_valid || advance;
    assign in_xfer    = i_in_valid && o_in_ready;
    assign step       = r_s1_valid && advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_s1_valid <= i_in_valid;
        end
    end

    // Low SAMPLE_BITS of each field form the sample.
    assign samples[0] = i_sample_ch0[weod_pkg::SAMPLE_BITS-1:0];
    if (weod_pkg::LANES > 1) begin : g_ch1
        assign samples[1] = i_sample_ch1[weod_pkg::SAMPLE_BITS-1:0];
    end

    for (genvar c = 0; c < weod_pkg::LANES; c++) begin : g_lane
        weod_square_lane u_lane (
            .i_clk    (i_clk),
            .i_en     (in_xfer),
            .i_sample (weod_pkg::t_sample'(samples[c])),
            .o_square (square[c])
        );
    end

    weod_window_acc u_acc (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_step            (step),
        .i_square          (square),
        .i_window_length   (r_window_length),
        .i_active_channels (r_active_channels),
        .o_close           (close),
        .o_closed          (closed)
    );

    weod_onset_out u_out (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_close         (close),
        .i_closed        (closed),
        .i_threshold     (r_rise_threshold),
        .i_out_ready     (i_out_ready),
        .o_advance       (advance),
        .o_out_valid     (o_out_valid),
        .o_onset_sample  (o_onset_sample),
        .o_window_energy (o_window_energy),
        .o_energy_rise   (o_energy_rise)
    );

    // A rise never exceeds the window energy it came from.
    `ASSERT_ALWAYS(a_rise_le_energy, !o_out_valid || (o_window_energy >= o_energy_rise))
    // Input backs up only when both the square stage and evaluator are blocked.
    `ASSERT_ALWAYS(a_ready_low_cause, o_in_ready || (r_s1_valid && !advance))
    // A blocked square stage keeps its frame.
    `ASSERT_NEXT(a_s1_hold, r_s1_valid && !advance, r_s1_valid)

endmodule
`default_nettype wire

[tb/window_energy_onset_detector_tb.sv]
// ----------------------------------------------------------------------------
// window_energy_onset_detector_tb
// Self-checking bench for the window energy onset detector. A queue-fed
// driver offers audio frames. A bit-accurate predictor updates a software
// copy of the window state on every input transfer and queues the onsets it
// expects. A monitor compares each output transfer, field by field, with
// the oldest queued onset. Directed frames cover the field extremes and the
// corner cases. Random phases follow, under several register settings and
// three idle profiles, with one long output stall and a trailing partial
// window at the end.
// ----------------------------------------------------------------------------
module window_energy_onset_detector_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // Drain after the last transfer before a register write: covers the square,
    // evaluator and output registers plus margin.
    localparam int DRAIN_CYCLES   = 8;
    localparam int RX_HOLD_CYCLES = 400;
    localparam int END_WAIT_LIMIT = 20000;

    // Index slot with no register behind it; writes to it must be ignored.
    localparam logic [weod_pkg::CFG_IDX_W-1:0] CFG_UNUSED_SLOT = 2'd3;

    typedef enum int unsigned {
        LOUD_QUIET,
        LOUD_SOFT,
        LOUD_FULL,
        LOUD_EDGE
    } t_loudness;

    typedef struct {
        logic [weod_pkg::FIELD_W-1:0] ch0;
        logic [weod_pkg::FIELD_W-1:0] ch1;
    } t_frame;

    typedef struct {
        logic [weod_pkg::IDX_W-1:0] start;
        logic [weod_pkg::E_W-1:0]   energy;
        logic [weod_pkg::E_W-1:0]   rise;
    } t_onset;

    // ------------------------------------------------------------------
    // DUT signals; all inputs known from time zero
    // ------------------------------------------------------------------
    logic                                  i_clk        = 1'b0;
    logic                                  i_rst_n      = 1'b0;
    logic                                  i_cfg_we     = 1'b0;
    logic [weod_pkg::CFG_IDX_W-1:0]        i_cfg_index  = '0;
    logic [weod_pkg::CFG_DATA_W-1:0]       i_cfg_data   = '0;
    logic                                  i_in_valid   = 1'b0;
    logic                                  o_in_ready;
    logic signed [weod_pkg::FIELD_W-1:0]   i_sample_ch0 = '0;
    logic signed [weod_pkg::FIELD_W-1:0]   i_sample_ch1 = '0;
    logic                                  o_out_valid;
    logic                                  i_out_ready  = 1'b0;
    logic [weod_pkg::IDX_W-1:0]            o_onset_sample;
    logic [weod_pkg::E_W-1:0]              o_window_energy;
    logic [weod_pkg::E_W-1:0]              o_energy_rise;

    window_energy_onset_detector DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_sample_ch0    (i_sample_ch0),
        .i_sample_ch1    (i_sample_ch1),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_onset_sample  (o_onset_sample),
        .o_window_energy (o_window_energy),
        .o_energy_rise   (o_energy_rise)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Bench state
    // ------------------------------------------------------------------
    t_frame frames_to_send[$];
    t_onset pending_onsets[$];
    int     mismatch_count = 0;

    // Idle profile, in percent of cycles
    int unsigned tx_idle_pct = 0;
    int unsigned rx_idle_pct = 0;
    bit          tx_hold     = 1'b0;

    // Long receiver hold-off: the stimulus bumps the request count, the
    // receiver process counts the stretch out on its own.
    int unsigned rx_hold_req  = 0;
    int unsigned rx_hold_seen = 0;
    int unsigned rx_hold_left = 0;

    // Register shadow, updated at the write
    logic [weod_pkg::LEN_W-1:0] cfg_window    = weod_pkg::RST_WINDOW_LENGTH;
    logic [weod_pkg::E_W-1:0]   cfg_threshold = weod_pkg::RST_RISE_THRESHOLD;
    logic [weod_pkg::CH_W-1:0]  cfg_channels  = weod_pkg::RST_ACTIVE_CHANNELS;

    // Predicted window state
    logic [weod_pkg::E_W-1:0]   win_energy = '0;
    logic [weod_pkg::E_W-1:0]   ref_energy = '0;
    logic                       ref_valid  = 1'b0;
    logic [weod_pkg::LEN_W-1:0] win_pos    = '0;
    logic [weod_pkg::IDX_W-1:0] win_start  = '0;

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        $display("[%0t] MISMATCH: %s", $time, msg);
    endtask

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    // Square of a SAMPLE_BITS two's complement code taken from the field's
    // low bits; -full scale squares to 2^(2*SAMPLE_BITS-2).
    function automatic logic [weod_pkg::SQ_W-1:0] sample_square(
        input logic [weod_pkg::FIELD_W-1:0] raw
    );
        logic [weod_pkg::SQ_W-1:0] mag;
        mag = raw[weod_pkg::SAMPLE_BITS-1]
            ? ((weod_pkg::SQ_W'(1) << weod_pkg::SAMPLE_BITS)
               - raw[weod_pkg::SAMPLE_BITS-1:0])
            : weod_pkg::SQ_W'(raw[weod_pkg::SAMPLE_BITS-1:0]);
        return mag * mag;
    endfunction

    task automatic accumulate_frame(input logic [weod_pkg::FIELD_W-1:0] s0,
                                    input logic [weod_pkg::FIELD_W-1:0] s1);
        int unsigned                lanes;
        logic [weod_pkg::E_W:0]     sum;
        logic [weod_pkg::LEN_W:0]   eff_len;
        logic [weod_pkg::IDX_W-1:0] span;
        t_onset                     hit;
        // channel count 0 acts as 1; above the lane count it saturates
        lanes = (cfg_channels == 0) ? 1 : cfg_channels;
        if (lanes > weod_pkg::LANES)
            lanes = weod_pkg::LANES;
        for (int c = 0; c < lanes; c++) begin
            sum = {1'b0, win_energy} + sample_square(c == 0 ? s0 : s1);
            win_energy = (sum > {1'b0, weod_pkg::E_MAX}) ? weod_pkg::E_MAX
                                                          : sum[weod_pkg::E_W-1:0];
        end
        win_pos = win_pos + 1'b1;
        // zero length acts as one; a lowered length closes on this frame
        eff_len = (cfg_window == 0) ? (weod_pkg::LEN_W+1)'(1) : {1'b0, cfg_window};
        if (win_pos != 0 && {1'b0, win_pos} < eff_len)
            return;
        span = (win_pos == 0) ? weod_pkg::IDX_W'(1 << weod_pkg::LEN_W)
                              : weod_pkg::IDX_W'(win_pos);
        // strict rise only; the first window just sets the reference
        if (ref_valid && win_energy > ref_energy &&
            (win_energy - ref_energy) > cfg_threshold) begin
            hit.start  = win_start;
            hit.energy = win_energy;
            hit.rise   = win_energy - ref_energy;
            pending_onsets = {pending_onsets, hit};
        end
        ref_energy = win_energy;
        ref_valid  = 1'b1;
        win_energy = '0;
        win_pos    = '0;
        win_start  = win_start + span;
    endtask

    // ------------------------------------------------------------------
    // Input driver: pops the frame queue, keeps valid up until transfer
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : frame_driver
        t_frame f;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            // input transfer at this edge: update the prediction
            if (i_in_valid && o_in_ready)
                accumulate_frame(i_sample_ch0, i_sample_ch1);
            // slot free after this edge: offer the next frame or idle
            if (!i_in_valid || o_in_ready) begin
                if (frames_to_send.size() != 0 && !tx_hold &&
                    $urandom_range(99) >= tx_idle_pct) begin
                    f = frames_to_send.pop_front();
                    i_sample_ch0 <= f.ch0;
                    i_sample_ch1 <= f.ch1;
                    i_in_valid   <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Output ready: random idling, or a long counted hold-off on request
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : onset_receiver
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (rx_hold_seen != rx_hold_req) begin
            rx_hold_seen <= rx_hold_req;
            rx_hold_left <= RX_HOLD_CYCLES;
            i_out_ready  <= 1'b0;
        end else if (rx_hold_left != 0) begin
            rx_hold_left <= rx_hold_left - 1;
            i_out_ready  <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // ------------------------------------------------------------------
    // Monitor: each output transfer against the oldest expected onset
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : onset_monitor
        t_onset want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_onsets.size() == 0) begin
                report_mismatch($sformatf("unexpected onset start=%0d energy=%0d rise=%0d",
                                          o_onset_sample, o_window_energy, o_energy_rise));
            end else begin
                want = pending_onsets.pop_front();
                if (o_onset_sample !== want.start)
                    report_mismatch($sformatf("onset_sample %0d, expected %0d",
                                              o_onset_sample, want.start));
                if (o_window_energy !== want.energy)
                    report_mismatch($sformatf("window_energy %0d, expected %0d",
                                              o_window_energy, want.energy));
                if (o_energy_rise !== want.rise)
                    report_mismatch($sformatf("energy_rise %0d, expected %0d",
                                              o_energy_rise, want.rise));
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic send_frame(input logic [weod_pkg::FIELD_W-1:0] ch0,
                              input logic [weod_pkg::FIELD_W-1:0] ch1);
        t_frame f;
        f.ch0 = ch0;
        f.ch1 = ch1;
        frames_to_send = {frames_to_send, f};
    endtask

    // Wait for the queue to empty, every onset to arrive, then the pipe to drain.
    task automatic settle();
        while (frames_to_send.size() != 0 || i_in_valid || pending_onsets.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // One-cycle register write; the shadow follows the register's width.
    task automatic cfg_write(input logic [weod_pkg::CFG_IDX_W-1:0] idx,
                             input logic [weod_pkg::CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        case (idx)
            weod_pkg::CFG_WINDOW_LENGTH:
                cfg_window    = data[weod_pkg::LEN_W-1:0];
            weod_pkg::CFG_RISE_THRESHOLD:
                cfg_threshold = data[weod_pkg::E_W-1:0];
            weod_pkg::CFG_ACTIVE_CHANNELS:
                cfg_channels  = data[weod_pkg::CH_W-1:0];
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    function automatic logic [weod_pkg::FIELD_W-1:0] rand_sample(input t_loudness level);
        int v;
        // occasional noise frame at any level
        if ($urandom_range(7) == 0)
            return weod_pkg::FIELD_W'($urandom);
        case (level)
            LOUD_QUIET: v = int'($urandom_range(8)) - 4;
            LOUD_SOFT:  v = int'($urandom_range(511)) - 256;
            LOUD_FULL:  v = int'($urandom_range(65535)) - 32768;
            default: begin
                case ($urandom_range(3))
                    0:       v = -32768;
                    1:       v = 32767;
                    2:       v = -32767;
                    default: v = 0;
                endcase
            end
        endcase
        return weod_pkg::FIELD_W'(v);
    endfunction

    // Random phases: per phase a new setting, then whole windows of frames
    // at one loudness each so that rises and falls both occur, sometimes a
    // trailing partial window. Optionally pauses the sender once mid-phase
    // until every expected onset is out.
    task automatic random_run(input int unsigned budget, input bit do_pause);
        int unsigned     sent;
        int unsigned     r;
        int unsigned     len;
        int unsigned     eff;
        int unsigned     nwin;
        int unsigned     pushed;
        longint unsigned thr;
        t_loudness       level;
        bit              pause_left;
        sent = 0;
        pause_left = do_pause;
        while (sent < budget) begin
            r = $urandom_range(99);
            if (r < 5)
                len = 0;
            else if (r < 70)
                len = $urandom_range(1, 8);
            else if (r < 95)
                len = $urandom_range(9, 64);
            else
                len = $urandom_range(65, 400);
            eff = (len == 0) ? 1 : len;
            case ($urandom_range(4))
                0:       thr = 0;
                1:       thr = $urandom_range(1 << 20);
                2:       thr = longint'(eff) * $urandom_range(1 << 30);
                3:       thr = {$urandom, $urandom} & longint'(weod_pkg::E_MAX);
                default: thr = weod_pkg::E_MAX;
            endcase
            cfg_write(weod_pkg::CFG_WINDOW_LENGTH, weod_pkg::CFG_DATA_W'(len));
            cfg_write(weod_pkg::CFG_RISE_THRESHOLD, weod_pkg::CFG_DATA_W'(thr));
            cfg_write(weod_pkg::CFG_ACTIVE_CHANNELS,
                      weod_pkg::CFG_DATA_W'($urandom_range(3)));
            nwin = (eff > 64) ? 2 : $urandom_range(3, 12);
            pushed = 0;
            for (int w = 0; w < nwin; w++) begin
                level = t_loudness'($urandom_range(3));
                for (int k = 0; k < eff; k++) begin
                    send_frame(rand_sample(level), rand_sample(level));
                    pushed++;
                end
            end
            if (eff > 1 && $urandom_range(3) == 0) begin
                for (int k = $urandom_range(1, eff - 1); k > 0; k--) begin
                    send_frame(rand_sample(LOUD_FULL), rand_sample(LOUD_FULL));
                    pushed++;
                end
            end
            if (pause_left) begin
                pause_left = 1'b0;
                while (frames_to_send.size() > pushed / 2)
                    @(negedge i_clk);
                tx_hold = 1'b1;
                while (i_in_valid || pending_onsets.size() != 0)
                    @(negedge i_clk);
                tx_hold = 1'b0;
            end
            sent += pushed;
            settle();
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin : stimulus
        int unsigned waited;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        tx_idle_pct = 36;
        rx_idle_pct = 68;

        // Directed: two-sample windows, zero threshold, reset channel count
        cfg_write(weod_pkg::CFG_WINDOW_LENGTH, weod_pkg::CFG_DATA_W'(2));
        cfg_write(weod_pkg::CFG_RISE_THRESHOLD, '0);
        send_frame(16'h0000, 16'h0000);         // first window: reference only
        send_frame(16'h0000, 16'h0000);
        send_frame(16'h7FFF, 16'h8000);         // full-scale rise
        send_frame(16'h8000, 16'h7FFF);
        send_frame(16'h7FFF, 16'h8000);         // equal energy: no onset
        send_frame(16'h8000, 16'h7FFF);
        send_frame(16'h0000, 16'h0000);         // fall: no onset
        send_frame(16'h0000, 16'h0000);
        settle();

        // Rise exactly at the threshold is not an onset, one above is
        cfg_write(weod_pkg::CFG_RISE_THRESHOLD, weod_pkg::CFG_DATA_W'(64'd1 << 32));
        send_frame(16'h8000, 16'h8000);
        send_frame(16'h8000, 16'h8000);
        send_frame(16'h0000, 16'h0000);
        send_frame(16'h0000, 16'h0000);
        settle();
        cfg_write(weod_pkg::CFG_RISE_THRESHOLD,
                  weod_pkg::CFG_DATA_W'((64'd1 << 32) - 1));
        send_frame(16'h8000, 16'h8000);
        send_frame(16'h8000, 16'h8000);
        settle();

        // Maximum threshold never fires
        cfg_write(weod_pkg::CFG_RISE_THRESHOLD, weod_pkg::CFG_DATA_W'(weod_pkg::E_MAX));
        send_frame(16'h0000, 16'h0000);
        send_frame(16'h0000, 16'h0000);
        send_frame(16'h8000, 16'h8000);
        send_frame(16'h8000, 16'h8000);
        settle();

        // One channel: second field ignored
        cfg_write(weod_pkg::CFG_RISE_THRESHOLD, '0);
        cfg_write(weod_pkg::CFG_ACTIVE_CHANNELS, weod_pkg::CFG_DATA_W'(1));
        send_frame(16'h0000, 16'h7FFF);
        send_frame(16'h0000, 16'h7FFF);
        send_frame(16'h0001, 16'h7FFF);
        send_frame(16'hFFFF, 16'h8000);
        settle();

        // Channel count zero acts as one
        cfg_write(weod_pkg::CFG_ACTIVE_CHANNELS, '0);
        send_frame(16'h0003, 16'h8000);
        send_frame(16'hFFFD, 16'h8000);
        settle();

        // Channel count three saturates to two; zero length acts as one
        cfg_write(weod_pkg::CFG_ACTIVE_CHANNELS, weod_pkg::CFG_DATA_W'(3));
        cfg_write(weod_pkg::CFG_WINDOW_LENGTH, '0);
        send_frame(16'h0001, 16'h0001);
        send_frame(16'h8000, 16'h8000);
        settle();

        // Length lowered mid-window: closes on the next frame
        cfg_write(weod_pkg::CFG_WINDOW_LENGTH, weod_pkg::CFG_DATA_W'(8));
        repeat (5) send_frame(16'h0010, 16'h0010);
        settle();
        cfg_write(weod_pkg::CFG_WINDOW_LENGTH, weod_pkg::CFG_DATA_W'(3));
        send_frame(16'h7FFF, 16'h7FFF);
        settle();

        // Write to the unused index slot has no effect
        cfg_write(CFG_UNUSED_SLOT, weod_pkg::CFG_DATA_W'({$urandom, $urandom}));
        send_frame(16'h0000, 16'h0000);
        send_frame(16'h0000, 16'h0000);
        send_frame(16'h0000, 16'h0000);
        settle();

        // Random, sender sparse and receiver mostly stalled
        random_run(220, 1'b1);

        // Random, roles swapped
        tx_idle_pct = 68;
        rx_idle_pct = 36;
        random_run(220, 1'b0);

        // Full rate from here on
        tx_idle_pct = 0;
        rx_idle_pct = 0;

        // Back-pressure: onset every other frame while the receiver holds
        // off, so the output register fills and the input stalls.
        cfg_write(weod_pkg::CFG_WINDOW_LENGTH, weod_pkg::CFG_DATA_W'(1));
        cfg_write(weod_pkg::CFG_RISE_THRESHOLD, '0);
        cfg_write(weod_pkg::CFG_ACTIVE_CHANNELS, weod_pkg::CFG_DATA_W'(1));
        rx_hold_req++;
        for (int k = 0; k < 50; k++) begin
            send_frame(16'h0000, weod_pkg::FIELD_W'($urandom));
            send_frame(16'h8000, weod_pkg::FIELD_W'($urandom));
        end
        settle();

        random_run(220, 1'b0);

        // Trailing partial window: never completed, so never evaluated
        cfg_write(weod_pkg::CFG_WINDOW_LENGTH, weod_pkg::CFG_DATA_W'(16));
        cfg_write(weod_pkg::CFG_RISE_THRESHOLD, '0);
        cfg_write(weod_pkg::CFG_ACTIVE_CHANNELS, weod_pkg::CFG_DATA_W'(2));
        repeat (10) send_frame(rand_sample(LOUD_FULL), rand_sample(LOUD_FULL));

        // End: everything sent, then a bounded wait for the remaining onsets
        while (frames_to_send.size() != 0 || i_in_valid)
            @(negedge i_clk);
        waited = 0;
        while (pending_onsets.size() != 0 && waited < END_WAIT_LIMIT) begin
            @(negedge i_clk);
            waited++;
        end
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (pending_onsets.size() != 0)
            report_mismatch($sformatf("%0d expected onsets never arrived",
                                      pending_onsets.size()));
        if (mismatch_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // Watchdog, far above the slowest correct run
    initial begin : watchdog
        #2_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
